// File: hdl/lkv_pkg.sv
// shared types, codes and helpers of the lru-k victim selector
package lkv_pkg;

   localparam int OP_W     = 3;
   localparam int ID_W     = 32;
   localparam int TIME_W   = 48;
   localparam int COUNT_W  = 16;
   localparam int PERIOD_W = 32;
   localparam int STATUS_W = 3;

   localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [OP_W-1:0] {
      OP_CREATE      = 3'd0,
      OP_EVICT       = 3'd1,
      OP_REFERENCE   = 3'd2,
      OP_UNREFERENCE = 3'd3,
      OP_DELETE      = 3'd4,
      OP_CHOOSE      = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      RS_OK        = 3'd0,
      RS_NO_VICTIM = 3'd1,
      RS_FULL      = 3'd2,
      RS_BAD_UNREF = 3'd3,
      RS_SATURATED = 3'd4
   } rsp_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_CALC,
      S_APPLY,
      S_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic scan;
      logic calc;
      logic apply;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
   } stat_type;

   // true when the gap since the last reference exceeds the period
   function automatic logic past_period(input logic [TIME_W-1:0] now,
                                        input logic [TIME_W-1:0] last,
                                        input logic [PERIOD_W-1:0] period);
      logic [TIME_W-1:0] gap;
      gap = (now > last) ? (now - last) : '0;
      return gap > {{(TIME_W-PERIOD_W){1'b0}}, period};
   endfunction

endpackage

// File: hdl/lkv_req_if.sv
// request channel interface: op, block id and time
interface lkv_req_if;
   import lkv_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [ID_W-1:0]     blk_id;
   logic [TIME_W-1:0]   now_time;
   modport source (output valid, op, blk_id, now_time, input ready);
   modport sink (input valid, op, blk_id, now_time, output ready);
endinterface

// File: hdl/lkv_rsp_if.sv
// response channel interface: status, victim id and reference count
interface lkv_rsp_if;
   import lkv_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     victim_id;
   logic [COUNT_W-1:0]  use_count;
   modport source (output valid, status, victim_id, use_count, input ready);
   modport sink (input valid, status, victim_id, use_count, output ready);
endinterface

// File: hdl/lkv_datapath.sv
// datapath: entry memory, flags, table scan, update and result registers
module lkv_datapath #(
   parameter int HISTORY_DEPTH = 2,
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lkv_pkg::cmd_type          cmd,
   output lkv_pkg::stat_type         stat,
   input  logic [lkv_pkg::OP_W-1:0]  req_op,
   input  logic [lkv_pkg::ID_W-1:0]  req_blk_id,
   input  logic [lkv_pkg::TIME_W-1:0] req_now_time,
   input  logic                      csr_write_enable,
   input  logic [lkv_pkg::PERIOD_W-1:0] csr_write_data,
   output logic [lkv_pkg::STATUS_W-1:0] rsp_status,
   output logic [lkv_pkg::ID_W-1:0]  rsp_victim_id,
   output logic [lkv_pkg::COUNT_W-1:0] rsp_use_count
);
   import lkv_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES);
   localparam int HK = HISTORY_DEPTH - 1;

   typedef logic [HISTORY_DEPTH-1:0][TIME_W-1:0] hist_type;

   // entry memory
   logic [ID_W-1:0]    mem_tag   [TABLE_ENTRIES];
   logic [COUNT_W-1:0] mem_count [TABLE_ENTRIES];
   logic [TIME_W-1:0]  mem_last  [TABLE_ENTRIES];
   hist_type           mem_hist  [TABLE_ENTRIES];

   logic [TABLE_ENTRIES-1:0] valid_ff, resident_ff, unref_ff;

   logic [PERIOD_W-1:0] period_ff;
   op_type              op_ff;
   logic [ID_W-1:0]     id_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [CNT_W-1:0]    cnt_ff;

   logic                rd_live_ff;
   logic [IDX_W-1:0]    rd_idx_ff;
   logic [ID_W-1:0]     rd_tag_ff;
   logic [COUNT_W-1:0]  rd_count_ff;
   logic [TIME_W-1:0]   rd_last_ff;
   hist_type            rd_hist_ff;

   logic                found_ff, best_past_ff, free_found_ff;
   logic [IDX_W-1:0]    slot_ff, free_slot_ff;
   logic [ID_W-1:0]     sel_tag_ff;
   logic [COUNT_W-1:0]  sel_count_ff;
   logic [TIME_W-1:0]   sel_last_ff;
   hist_type            sel_hist_ff;

   logic [TIME_W-1:0]   span_ff, span_in;
   logic                push_ff, push_in;

   rsp_status_type      res_status_ff, out_status_ff;
   logic [ID_W-1:0]     res_victim_ff, out_victim_ff;
   logic [COUNT_W-1:0]  res_count_ff, out_count_ff;

   // scan evaluation
   logic cand_past, entry_live, is_match, is_cand, better, take, take_free;

   always_comb begin
      cand_past  = past_period(now_ff, rd_last_ff, period_ff);
      entry_live = rd_live_ff && valid_ff[rd_idx_ff];
      is_match   = entry_live && (rd_tag_ff == id_ff);
      is_cand    = entry_live && unref_ff[rd_idx_ff] && resident_ff[rd_idx_ff];
      better     = !found_ff || (cand_past && !best_past_ff) ||
                   ((cand_past == best_past_ff) && (rd_hist_ff[HK] < sel_hist_ff[HK]));
      take       = (op_ff == OP_CHOOSE) ? (is_cand && better) : (is_match && !found_ff);
      take_free  = rd_live_ff && !valid_ff[rd_idx_ff] && !free_found_ff;
   end

   assign stat.scan_done = cmd.scan && (cnt_ff == LAST_CNT);

   // effective entry after a possible allocation
   logic               alloc, have;
   logic [IDX_W-1:0]   s_idx;
   logic [ID_W-1:0]    e_tag;
   logic [COUNT_W-1:0] e_count;
   logic [TIME_W-1:0]  e_last;
   hist_type           e_hist;
   logic               e_res, e_unref;

   always_comb begin
      alloc   = ((op_ff == OP_CREATE) || (op_ff == OP_REFERENCE)) && !found_ff && free_found_ff;
      have    = found_ff || alloc;
      s_idx   = found_ff ? slot_ff : free_slot_ff;
      e_tag   = alloc ? id_ff : sel_tag_ff;
      e_count = alloc ? '0 : sel_count_ff;
      e_last  = alloc ? '0 : sel_last_ff;
      e_hist  = alloc ? '0 : sel_hist_ff;
      e_res   = alloc ? 1'b0 : resident_ff[s_idx];
      e_unref = alloc ? 1'b0 : unref_ff[s_idx];
      span_in = (e_res && (e_hist[0] != '0) && (e_last > e_hist[0])) ?
                (e_last - e_hist[0]) : '0;
      push_in = !e_res || past_period(now_ff, e_last, period_ff);
   end

   // shifted history
   hist_type           new_hist;
   logic [TIME_W:0]    sum;

   always_comb begin
      new_hist    = '0;
      sum         = '0;
      new_hist[0] = now_ff;
      for (int j = 1; j < HISTORY_DEPTH; j++) begin
         sum = {1'b0, e_hist[j-1]} + {1'b0, span_ff};
         if (e_hist[j-1] == '0) begin
            new_hist[j] = '0;
         end else if (sum[TIME_W]) begin
            new_hist[j] = TIME_MAX;
         end else begin
            new_hist[j] = sum[TIME_W-1:0];
         end
      end
   end

   // per-op update
   logic               mem_we, fl_we, fl_valid, fl_res, fl_unref;
   logic [COUNT_W-1:0] w_count;
   logic [TIME_W-1:0]  w_last;
   hist_type           w_hist;
   rsp_status_type     o_status;
   logic [ID_W-1:0]    o_victim;
   logic [COUNT_W-1:0] o_count;

   always_comb begin
      mem_we   = 1'b0;
      fl_we    = 1'b0;
      fl_valid = 1'b1;
      fl_res   = e_res;
      fl_unref = e_unref;
      w_count  = e_count;
      w_last   = e_last;
      w_hist   = e_hist;
      o_status = RS_OK;
      o_victim = '0;
      o_count  = '0;
      case (op_ff)
         OP_CREATE: begin
            if (!have) begin
               o_status = RS_FULL;
            end else begin
               mem_we   = 1'b1;
               fl_we    = 1'b1;
               fl_res   = 1'b1;
               fl_unref = 1'b1;
               o_count  = e_count;
            end
         end
         OP_EVICT: begin
            if (found_ff) begin
               fl_we    = 1'b1;
               fl_res   = 1'b0;
               fl_unref = 1'b0;
               o_count  = e_count;
            end
         end
         OP_REFERENCE: begin
            if (!have) begin
               o_status = RS_FULL;
            end else begin
               mem_we = 1'b1;
               fl_we  = 1'b1;
               fl_res = 1'b1;
               w_last = now_ff;
               w_hist = push_ff ? new_hist : e_hist;
               if (e_count == '0) begin
                  fl_unref = 1'b0;
               end
               if (e_count == COUNT_MAX) begin
                  o_status = RS_SATURATED;
               end else begin
                  w_count = e_count + COUNT_W'(1);
               end
               o_count = w_count;
            end
         end
         OP_UNREFERENCE: begin
            if (!found_ff || (e_count == '0)) begin
               o_status = RS_BAD_UNREF;
               o_count  = found_ff ? e_count : '0;
            end else begin
               mem_we  = 1'b1;
               fl_we   = 1'b1;
               w_count = e_count - COUNT_W'(1);
               if (w_count == '0) begin
                  fl_unref = 1'b1;
               end
               o_count = w_count;
            end
         end
         OP_DELETE: begin
            if (found_ff) begin
               fl_we    = 1'b1;
               fl_valid = 1'b0;
               fl_res   = 1'b0;
               fl_unref = 1'b0;
            end
         end
         OP_CHOOSE: begin
            if (!found_ff) begin
               o_status = RS_NO_VICTIM;
            end else begin
               fl_we    = 1'b1;
               fl_res   = 1'b0;
               fl_unref = 1'b0;
               o_victim = e_tag;
               o_count  = e_count;
            end
         end
         default: begin
            o_status = RS_OK;
         end
      endcase
   end

   // memory read and write
   always_ff @(posedge clock) begin
      if (cmd.scan && (cnt_ff < LAST_CNT)) begin
         rd_tag_ff   <= mem_tag[cnt_ff[IDX_W-1:0]];
         rd_count_ff <= mem_count[cnt_ff[IDX_W-1:0]];
         rd_last_ff  <= mem_last[cnt_ff[IDX_W-1:0]];
         rd_hist_ff  <= mem_hist[cnt_ff[IDX_W-1:0]];
         rd_idx_ff   <= cnt_ff[IDX_W-1:0];
      end
      if (cmd.apply && mem_we) begin
         mem_tag[s_idx]   <= e_tag;
         mem_count[s_idx] <= w_count;
         mem_last[s_idx]  <= w_last;
         mem_hist[s_idx]  <= w_hist;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= op_type'(req_op);
         id_ff  <= req_blk_id;
         now_ff <= req_now_time;
      end
      if (cmd.scan && take) begin
         slot_ff      <= rd_idx_ff;
         sel_tag_ff   <= rd_tag_ff;
         sel_count_ff <= rd_count_ff;
         sel_last_ff  <= rd_last_ff;
         sel_hist_ff  <= rd_hist_ff;
         best_past_ff <= cand_past;
      end
      if (cmd.scan && take_free) begin
         free_slot_ff <= rd_idx_ff;
      end
      if (cmd.calc) begin
         span_ff <= span_in;
         push_ff <= push_in;
      end
      if (cmd.load) begin
         out_status_ff <= res_status_ff;
         out_victim_ff <= res_victim_ff;
         out_count_ff  <= res_count_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff     <= '0;
         valid_ff      <= '0;
         resident_ff   <= '0;
         unref_ff      <= '0;
         cnt_ff        <= '0;
         rd_live_ff    <= 1'b0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         res_status_ff <= RS_OK;
         res_victim_ff <= '0;
         res_count_ff  <= '0;
      end else begin
         if (csr_write_enable) begin
            period_ff <= csr_write_data;
         end
         if (cmd.capture) begin
            cnt_ff        <= '0;
            rd_live_ff    <= 1'b0;
            found_ff      <= 1'b0;
            free_found_ff <= 1'b0;
         end
         if (cmd.scan) begin
            if (cnt_ff < LAST_CNT) begin
               cnt_ff <= cnt_ff + CNT_W'(1);
            end
            rd_live_ff <= (cnt_ff < LAST_CNT);
            if (take) begin
               found_ff <= 1'b1;
            end
            if (take_free) begin
               free_found_ff <= 1'b1;
            end
         end
         if (cmd.apply) begin
            if (fl_we) begin
               valid_ff[s_idx]    <= fl_valid;
               resident_ff[s_idx] <= fl_res;
               unref_ff[s_idx]    <= fl_unref;
            end
            res_status_ff <= o_status;
            res_victim_ff <= o_victim;
            res_count_ff  <= o_count;
         end
      end
   end

   assign rsp_status    = out_status_ff;
   assign rsp_victim_id = out_victim_ff;
   assign rsp_use_count = out_count_ff;

`ifndef SYNTHESIS
   a_scan_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (cnt_ff == '0) && !found_ff && !free_found_ff)
      else $error("scan state not cleared on new transaction");
   a_victim_released: assert property (@(posedge clock) disable iff (reset)
      (cmd.apply && (op_ff == OP_CHOOSE) && found_ff) |=>
         !unref_ff[$past(s_idx)] && !resident_ff[$past(s_idx)])
      else $error("victim still marked resident or unreferenced");
   a_victim_only_ok: assert property (@(posedge clock) disable iff (reset)
      (res_status_ff != RS_OK) |-> (res_victim_ff == '0))
      else $error("victim id set on failed transaction");
`endif
endmodule

// File: hdl/lkv_ctrl.sv
// controller: sequences capture, table scan, update and response
module lkv_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lkv_pkg::cmd_type  cmd,
   input  lkv_pkg::stat_type stat
);
   import lkv_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            state_in = S_APPLY;
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_IDLE) && req_valid) |=> (state_ff == S_SCAN))
      else $error("accepted transaction did not start a scan");
   a_finish_posts: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FINISH) && !rsp_valid_ff) |=> (rsp_valid_ff && (state_ff == S_IDLE)))
      else $error("finished transaction not posted");
   a_ready_when_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == S_IDLE))
      else $error("request taken outside idle");
`endif
endmodule

// File: hdl/lru_k_victim_selector.sv
// top level of the lru-k victim selector
//
//   channel   direction   payload
//   req_bus   in          op, blk_id, now_time
//   rsp_bus   out         status, victim_id, use_count
//   csr_*     in          correlated_period (write only)
//
// each transaction makes one sequential pass over the single-port entry memory,
// then steps through span, update and response
// reset clears all entry flags and the period; no clearing pass is needed
// a new request is taken while the previous response waits on rsp_bus
// a stalled rsp_bus holds the controller in its last step until taken
module lru_k_victim_selector #(
   parameter int HISTORY_DEPTH = 2,
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   lkv_req_if.sink                       req_bus,
   lkv_rsp_if.source                     rsp_bus,
   input  logic                          csr_write_enable,
   input  logic [lkv_pkg::PERIOD_W-1:0]  csr_write_data
);
   import lkv_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   lkv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   lkv_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_op           (req_bus.op),
      .req_blk_id       (req_bus.blk_id),
      .req_now_time     (req_bus.now_time),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_status       (rsp_bus.status),
      .rsp_victim_id    (rsp_bus.victim_id),
      .rsp_use_count    (rsp_bus.use_count)
   );
endmodule

// File: tb/sv/lkv_victim_checker.sv
// checker: predicts lru-k victim selector responses and compares them
module lkv_victim_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [lkv_pkg::OP_W-1:0]     req_op,
   input  logic [lkv_pkg::ID_W-1:0]     req_blk_id,
   input  logic [lkv_pkg::TIME_W-1:0]   req_now_time,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [lkv_pkg::STATUS_W-1:0] rsp_status,
   input  logic [lkv_pkg::ID_W-1:0]     rsp_victim_id,
   input  logic [lkv_pkg::COUNT_W-1:0]  rsp_use_count,
   input  logic                         csr_write_enable,
   input  logic [lkv_pkg::PERIOD_W-1:0] csr_write_data,
   output int                           fail_count,
   output int                           pending
);
   import lkv_pkg::*;

   localparam int DEPTH = 2;
   localparam int SLOTS = 16;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     victim_id;
      logic [COUNT_W-1:0]  use_count;
   } outcome_type;

   outcome_type outcome_q[$];
   logic [PERIOD_W-1:0] period;
   logic                slot_valid [SLOTS];
   logic [ID_W-1:0]     slot_tag [SLOTS];
   logic                slot_res [SLOTS];
   logic                slot_unref [SLOTS];
   logic [COUNT_W-1:0]  slot_count [SLOTS];
   logic [TIME_W-1:0]   slot_last [SLOTS];
   logic [TIME_W-1:0]   slot_hist [SLOTS][DEPTH];

   assign pending = outcome_q.size();

   function automatic logic gap_exceeds(int s, logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] gap;
      gap = (now > slot_last[s]) ? now - slot_last[s] : '0;
      return gap > {16'd0, period};
   endfunction

   function automatic int lookup(logic [ID_W-1:0] id);
      for (int i = 0; i < SLOTS; i++)
         if (slot_valid[i] && slot_tag[i] == id) return i;
      return -1;
   endfunction

   function automatic int allocate(logic [ID_W-1:0] id);
      for (int i = 0; i < SLOTS; i++)
         if (!slot_valid[i]) begin
            slot_valid[i] = 1; slot_tag[i] = id; slot_res[i] = 0;
            slot_unref[i] = 0; slot_count[i] = 0; slot_last[i] = 0;
            for (int h = 0; h < DEPTH; h++) slot_hist[i][h] = 0;
            return i;
         end
      return -1;
   endfunction

   function automatic void shift_history(int s, logic [TIME_W-1:0] now, logic correct);
      logic [TIME_W:0] span, v;
      span = 0;
      if (correct && slot_hist[s][0] != 0)
         span = (slot_last[s] > slot_hist[s][0]) ? slot_last[s] - slot_hist[s][0] : 0;
      for (int h = DEPTH - 1; h > 0; h--) begin
         v = 0;
         if (slot_hist[s][h-1] != 0) begin
            v = slot_hist[s][h-1] + span;
            if (v > TIME_MAX) v = TIME_MAX;
         end
         slot_hist[s][h] = v[TIME_W-1:0];
      end
      slot_hist[s][0] = now;
   endfunction

   function automatic outcome_type predict_event(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                                 logic [TIME_W-1:0] now);
      outcome_type r;
      int s, best;
      logic p, best_p;
      r = '0;
      case (op)
         OP_CREATE: begin
            s = lookup(id);
            if (s < 0) s = allocate(id);
            if (s < 0) r.status = RS_FULL;
            else begin
               slot_res[s] = 1; slot_unref[s] = 1; r.use_count = slot_count[s];
            end
         end
         OP_EVICT: begin
            s = lookup(id);
            if (s >= 0) begin
               slot_res[s] = 0; slot_unref[s] = 0; r.use_count = slot_count[s];
            end
         end
         OP_REFERENCE: begin
            s = lookup(id);
            if (s < 0) s = allocate(id);
            if (s < 0) r.status = RS_FULL;
            else begin
               if (slot_res[s]) begin
                  if (gap_exceeds(s, now)) shift_history(s, now, 1);
               end else begin
                  shift_history(s, now, 0);
                  slot_res[s] = 1;
               end
               slot_last[s] = now;
               if (slot_count[s] == 0) slot_unref[s] = 0;
               if (slot_count[s] == COUNT_MAX) r.status = RS_SATURATED;
               else slot_count[s]++;
               r.use_count = slot_count[s];
            end
         end
         OP_UNREFERENCE: begin
            s = lookup(id);
            if (s < 0 || slot_count[s] == 0) begin
               r.status = RS_BAD_UNREF;
               if (s >= 0) r.use_count = slot_count[s];
            end else begin
               slot_count[s]--;
               if (slot_count[s] == 0) slot_unref[s] = 1;
               r.use_count = slot_count[s];
            end
         end
         OP_DELETE: begin
            s = lookup(id);
            if (s >= 0) begin
               slot_valid[s] = 0; slot_res[s] = 0; slot_unref[s] = 0;
            end
         end
         OP_CHOOSE: begin
            best = -1; best_p = 0;
            for (int i = 0; i < SLOTS; i++) begin
               if (!(slot_valid[i] && slot_unref[i] && slot_res[i])) continue;
               p = gap_exceeds(i, now);
               if (best < 0 || (p && !best_p) ||
                   (p == best_p && slot_hist[i][DEPTH-1] < slot_hist[best][DEPTH-1])) begin
                  best = i; best_p = p;
               end
            end
            if (best < 0) r.status = RS_NO_VICTIM;
            else begin
               slot_res[best] = 0; slot_unref[best] = 0;
               r.victim_id = slot_tag[best]; r.use_count = slot_count[best];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      outcome_type got, want;
      if (reset) begin
         period <= '0;
         fail_count <= 0;
         outcome_q.delete();
         for (int i = 0; i < SLOTS; i++) begin
            slot_valid[i] = 0; slot_res[i] = 0; slot_unref[i] = 0;
         end
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_status, rsp_victim_id, rsp_use_count};
            if (outcome_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected response %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = outcome_q.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("mismatch: expected st=%0d id=%h cnt=%0d got st=%0d id=%h cnt=%0d",
                              want.status, want.victim_id, want.use_count,
                              got.status, got.victim_id, got.use_count);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready)
            outcome_q = {outcome_q, predict_event(req_op, req_blk_id, req_now_time)};
         if (csr_write_enable) period <= csr_write_data;
      end
   end
endmodule

// File: tb/sv/lru_k_victim_selector_tb.sv
// testbench top: stimulus for the lru-k victim selector and verdict
module lru_k_victim_selector_tb;
   import lkv_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [PERIOD_W-1:0] csr_write_data = '0;
   int fail_count, pending;
   logic [TIME_W-1:0] clock_now = 1;
   logic no_idle = 0;
   logic [ID_W-1:0] id_pool [8];

   lkv_req_if req_bus ();
   lkv_rsp_if rsp_bus ();

   lru_k_victim_selector u_dut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   lkv_victim_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_bus.valid), .req_ready(req_bus.ready), .req_op(req_bus.op),
      .req_blk_id(req_bus.blk_id), .req_now_time(req_bus.now_time),
      .rsp_valid(rsp_bus.valid), .rsp_ready(rsp_bus.ready), .rsp_status(rsp_bus.status),
      .rsp_victim_id(rsp_bus.victim_id), .rsp_use_count(rsp_bus.use_count),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .fail_count(fail_count), .pending(pending)
   );

   always #6 clock = ~clock;

   initial begin
      req_bus.valid = 0; req_bus.op = '0; req_bus.blk_id = '0; req_bus.now_time = 1;
      rsp_bus.ready = 0;
   end

   always @(posedge clock)
      rsp_bus.ready <= reset ? 1'b0 : (no_idle || $urandom_range(99) >= 27);

   task automatic send(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic [TIME_W-1:0] t);
      while (!no_idle && $urandom_range(99) < 27) begin
         req_bus.valid <= 0;
         @(posedge clock);
      end
      req_bus.valid <= 1; req_bus.op <= op; req_bus.blk_id <= id; req_bus.now_time <= t;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic drain();
      req_bus.valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_period(logic [PERIOD_W-1:0] v);
      drain();
      repeat (40) @(posedge clock);
      csr_write_enable <= 1; csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   task automatic tick(int unsigned maxstep);
      if (clock_now < TIME_MAX - maxstep) clock_now += TIME_W'($urandom_range(maxstep));
   endtask

   task automatic random_phase(int n, int unsigned maxstep);
      int k;
      logic [OP_W-1:0] op;
      for (int j = 0; j < n; j++) begin
         k = $urandom_range(99);
         if (k < 2) op = OP_W'(6 + $urandom_range(1));
         else if (k < 15) op = OP_CREATE;
         else if (k < 45) op = OP_REFERENCE;
         else if (k < 70) op = OP_UNREFERENCE;
         else if (k < 78) op = OP_EVICT;
         else if (k < 85) op = OP_DELETE;
         else op = OP_CHOOSE;
         tick(maxstep);
         send(op, ($urandom_range(9) == 0) ? $urandom : id_pool[$urandom_range(7)],
              clock_now);
      end
   endtask

   initial begin
      for (int i = 0; i < 8; i++) id_pool[i] = $urandom;
      id_pool[0] = '0; id_pool[1] = '1;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed
      send(OP_CHOOSE, '0, 1);
      send(OP_UNREFERENCE, 32'd5, 1);
      send(OP_EVICT, 32'd5, 1);
      send(OP_DELETE, 32'd5, 1);
      send(3'd7, '1, TIME_MAX);
      send(OP_REFERENCE, '0, 2);
      send(OP_REFERENCE, '0, 2);
      send(OP_CREATE, '1, 3);
      send(OP_CREATE, '0, 3);
      send(OP_UNREFERENCE, '0, 4);
      send(OP_UNREFERENCE, '0, 4);
      send(OP_UNREFERENCE, '0, 4);
      send(OP_CHOOSE, '0, 10);
      send(OP_CHOOSE, '0, 10);
      send(OP_CHOOSE, '0, 10);
      for (int i = 0; i < 17; i++) send(OP_CREATE, 32'h100 + i, 20);
      send(OP_REFERENCE, 32'h999, 21);
      send(OP_REFERENCE, 32'h100, TIME_MAX - 1);
      send(OP_REFERENCE, 32'h100, 5);
      for (int i = 0; i < 17; i++) send(OP_DELETE, 32'h100 + i, TIME_MAX);
      write_period('1);
      send(OP_CREATE, 32'h7, 1);
      send(OP_REFERENCE, 32'h7, 1);
      send(OP_UNREFERENCE, 32'h7, 1);
      send(OP_DELETE, 32'h7, 1);
      // random phases across period settings
      write_period(0);          random_phase(300, 8);
      write_period(5);          random_phase(300, 12);
      no_idle = 1;              random_phase(150, 12); no_idle = 0;
      write_period($urandom);   clock_now = 48'hFFFF_0000_0000;
      random_phase(200, 32'hFFFF_FFFF);
      write_period('1);         random_phase(200, 32'hFFFF_FFFF);
      write_period(3);          random_phase(150, 10);
      drain();
      repeat (40) @(posedge clock);
      if (fail_count == 0) $display("[lru_k_victim_selector] OK");
      else $display("[lru_k_victim_selector] ERROR");
      $finish;
   end

   initial begin
      #60000000;
      $display("[lru_k_victim_selector] ERROR");
      $finish;
   end
endmodule
